>>> rtl/core/i2c_master_bit_engine_macros.svh
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Shorthand for the concurrent checks of the bit engine, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2C_MBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2C_MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/i2c_mbe_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Command and phase codes, register indexes, the request types passed between
// the front and back parts, and the delay helper.
// ----------------------------------------------------------------------------
package i2c_mbe_pkg;

  // Bus commands carried in the mode field.
  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_WACK  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  // Sequencer phases of the back part.
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ST1   = 4'd1,
    PH_ST2   = 4'd2,
    PH_SP1   = 4'd3,
    PH_SP2   = 4'd4,
    PH_SP3   = 4'd5,
    PH_WSET  = 4'd6,
    PH_WHI   = 4'd7,
    PH_WLO   = 4'd8,
    PH_RLO   = 4'd9,
    PH_RHI   = 4'd10,
    PH_RALO  = 4'd11,
    PH_RAHI  = 4'd12,
    PH_AREL  = 4'd13,
    PH_AHI   = 4'd14,
    PH_APOLL = 4'd15
  } phase_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_TICKS_PER_UNIT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ACK_POLL_LIMIT = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [15:0] TICKS_PER_UNIT_RST = 16'd8;
  localparam logic [7:0]  ACK_POLL_LIMIT_RST = 8'd250;

  // Hold lengths as a shift of the unit tick count.
  localparam logic [1:0] HOLD_1U = 2'd0;
  localparam logic [1:0] HOLD_2U = 2'd1;
  localparam logic [1:0] HOLD_4U = 2'd2;

  // Width of the hold counter: four units of the largest unit length.
  localparam int unsigned DelayW = 18;

  // Number of bits in one byte transfer.
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // One classified tick request from the front part.
  typedef struct packed {
    logic       cmd_ok;
    cmd_e       mode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  // One result of a tick.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } res_t;

  // A configuration write request.
  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic [15:0]        data;
  } cfg_wr_t;

  // Reload value of the hold counter: hold length in ticks, minus one.
  // A unit length of zero counts as one tick.
  function automatic logic [DelayW-1:0] hold_delay(input logic [15:0] tpu,
                                                   input logic [1:0]  hold);
    logic [DelayW-1:0] t;
    t = (tpu == 16'd0) ? DelayW'(1) : DelayW'(tpu);
    return (t << hold) - DelayW'(1);
  endfunction

endpackage

>>> rtl/core/i2c_mbe_front.sv
// ----------------------------------------------------------------------------
// I2C master bit engine front part
// Accepts tick requests, classifies the command field and holds them in a
// two-entry queue for the back part.
// ----------------------------------------------------------------------------
module i2c_mbe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                cmd_valid_i,
  input  logic [2:0]          mode_i,
  input  logic [7:0]          tx_byte_i,
  input  logic                send_ack_i,
  input  logic                sda_in_i,
  output logic                item_valid_o,
  output i2c_mbe_pkg::item_t  item_o,
  input  logic                item_pop_i
);
  import i2c_mbe_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push_ok;
  logic       pop_ok;
  item_t      item_in;

  // Classify the request: only a known mode with cmd_valid is a command.
  always_comb begin
    item_in.cmd_ok   = cmd_valid_i &&
                       (mode_i inside {CMD_START, CMD_STOP, CMD_WRITE, CMD_WACK, CMD_READ});
    item_in.mode     = cmd_e'(mode_i);
    item_in.tx_byte  = tx_byte_i;
    item_in.send_ack = send_ack_i;
    item_in.sda_in   = sda_in_i;
  end

  // Queue control.
  assign full         = (cnt_q == 2'd2);
  assign push_ok      = push && !full;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop_ok       = item_pop_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_ok ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_ok ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

>>> rtl/core/i2c_mbe_back.sv
// ----------------------------------------------------------------------------
// I2C master bit engine back part
// Runs the bus sequencer one tick per request, holds the configuration
// registers and queues the results in a two-entry output queue.
// ----------------------------------------------------------------------------
module i2c_mbe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2c_mbe_pkg::cfg_wr_t  cfg_i,
  input  logic                  item_valid_i,
  input  i2c_mbe_pkg::item_t    item_i,
  output logic                  item_pop_o,
  output logic                  empty,
  input  logic                  pop,
  output i2c_mbe_pkg::res_t     res_o
);
  import i2c_mbe_pkg::*;

  // Configuration registers.
  logic [15:0] tpu_q;
  logic [7:0]  limit_q;

  // Sequencer state.
  phase_e            phase_q, phase_d;
  cmd_e              active_q, active_d;
  logic [3:0]        bit_q, bit_d;
  logic [7:0]        shift_q, shift_d;
  logic [DelayW-1:0] delay_q, delay_d;
  logic [7:0]        poll_q, poll_d;
  logic              ack_choice_q, ack_choice_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;

  logic       done;
  logic [7:0] rx;
  logic       failed;
  logic [3:0] bit_inc;
  logic [7:0] shift_in;
  logic       fire;
  res_t       res_in;

  // Result queue.
  res_t       rmem_q [2];
  logic       rwr_q, rrd_q;
  logic [1:0] rcnt_q, rcnt_d;
  logic       res_full;
  logic       rpop_ok;

  // Configuration writes; indexes outside the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q   <= TICKS_PER_UNIT_RST;
      limit_q <= ACK_POLL_LIMIT_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_TICKS_PER_UNIT) begin
        tpu_q <= cfg_i.data;
      end
      if (cfg_i.index == REG_ACK_POLL_LIMIT) begin
        limit_q <= cfg_i.data[7:0];
      end
    end
  end

  // A request is processed when the result queue has room.
  assign res_full   = (rcnt_q == 2'd2);
  assign fire       = item_valid_i && !res_full;
  assign item_pop_o = fire;

  assign bit_inc  = bit_q + 4'd1;
  assign shift_in = {shift_q[6:0], item_i.sda_in};

  // Sequencer next state for one tick.
  always_comb begin
    phase_d      = phase_q;
    active_d     = active_q;
    bit_d        = bit_q;
    shift_d      = shift_q;
    delay_d      = delay_q;
    poll_d       = poll_q;
    ack_choice_d = ack_choice_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    done         = 1'b0;
    rx           = 8'd0;
    failed       = 1'b0;

    if (phase_q == PH_IDLE) begin
      if (item_i.cmd_ok) begin
        active_d = item_i.mode;
        bit_d    = 4'd0;
        poll_d   = 8'd0;
        case (item_i.mode)
          CMD_START: begin
            scl_d   = 1'b1;
            sda_d   = 1'b1;
            phase_d = PH_ST1;
            delay_d = hold_delay(tpu_q, HOLD_4U);
          end
          CMD_STOP: begin
            scl_d   = 1'b0;
            sda_d   = 1'b0;
            phase_d = PH_SP1;
            delay_d = hold_delay(tpu_q, HOLD_4U);
          end
          CMD_WRITE: begin
            scl_d   = 1'b0;
            sda_d   = item_i.tx_byte[7];
            shift_d = {item_i.tx_byte[6:0], 1'b0};
            phase_d = PH_WSET;
            delay_d = hold_delay(tpu_q, HOLD_2U);
          end
          CMD_WACK: begin
            sda_d   = 1'b1;
            phase_d = PH_AREL;
            delay_d = hold_delay(tpu_q, HOLD_1U);
          end
          default: begin
            ack_choice_d = item_i.send_ack;
            shift_d      = 8'd0;
            scl_d        = 1'b0;
            sda_d        = 1'b1;
            phase_d      = PH_RLO;
            delay_d      = hold_delay(tpu_q, HOLD_2U);
          end
        endcase
      end
    end else if (delay_q != '0) begin
      delay_d = delay_q - DelayW'(1);
    end else begin
      case (phase_q)
        PH_ST1: begin
          scl_d   = 1'b1;
          sda_d   = 1'b0;
          phase_d = PH_ST2;
          delay_d = hold_delay(tpu_q, HOLD_4U);
        end
        PH_ST2: begin
          scl_d   = 1'b0;
          sda_d   = 1'b0;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
        PH_SP1: begin
          scl_d   = 1'b1;
          sda_d   = 1'b0;
          phase_d = PH_SP2;
          delay_d = hold_delay(tpu_q, HOLD_4U);
        end
        PH_SP2: begin
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          phase_d = PH_SP3;
          delay_d = hold_delay(tpu_q, HOLD_4U);
        end
        PH_SP3: begin
          phase_d = PH_IDLE;
          done    = 1'b1;
          failed  = (active_q == CMD_WACK);
        end
        PH_WSET: begin
          scl_d   = 1'b1;
          phase_d = PH_WHI;
          delay_d = hold_delay(tpu_q, HOLD_2U);
        end
        PH_WHI: begin
          scl_d   = 1'b0;
          phase_d = PH_WLO;
          delay_d = hold_delay(tpu_q, HOLD_2U);
        end
        PH_WLO: begin
          bit_d = bit_inc;
          if (bit_inc >= BITS_PER_BYTE) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else begin
            scl_d   = 1'b0;
            sda_d   = shift_q[7];
            shift_d = {shift_q[6:0], 1'b0};
            phase_d = PH_WSET;
            delay_d = hold_delay(tpu_q, HOLD_2U);
          end
        end
        PH_RLO: begin
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          phase_d = PH_RHI;
          delay_d = hold_delay(tpu_q, HOLD_1U);
        end
        PH_RHI: begin
          shift_d = shift_in;
          bit_d   = bit_inc;
          scl_d   = 1'b0;
          delay_d = hold_delay(tpu_q, HOLD_2U);
          if (bit_inc >= BITS_PER_BYTE) begin
            sda_d   = !ack_choice_q;
            phase_d = PH_RALO;
          end else begin
            sda_d   = 1'b1;
            phase_d = PH_RLO;
          end
        end
        PH_RALO: begin
          scl_d   = 1'b1;
          phase_d = PH_RAHI;
          delay_d = hold_delay(tpu_q, HOLD_2U);
        end
        PH_RAHI: begin
          scl_d   = 1'b0;
          phase_d = PH_IDLE;
          done    = 1'b1;
          rx      = shift_q;
        end
        PH_AREL: begin
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          phase_d = PH_AHI;
          delay_d = hold_delay(tpu_q, HOLD_1U);
        end
        default: begin
          // Acknowledge polling: low SDA ends the wait, too many highs fail it.
          if (!item_i.sda_in) begin
            scl_d   = 1'b0;
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else if ({1'b0, poll_q} + 9'd1 > {1'b0, limit_q}) begin
            scl_d   = 1'b0;
            sda_d   = 1'b0;
            phase_d = PH_SP1;
            delay_d = hold_delay(tpu_q, HOLD_4U);
          end else begin
            poll_d  = poll_q + 8'd1;
            phase_d = PH_APOLL;
            delay_d = '0;
          end
        end
      endcase
    end
  end

  // Sequencer registers advance once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      active_q     <= CMD_START;
      bit_q        <= 4'd0;
      shift_q      <= 8'd0;
      delay_q      <= '0;
      poll_q       <= 8'd0;
      ack_choice_q <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
    end else if (fire) begin
      phase_q      <= phase_d;
      active_q     <= active_d;
      bit_q        <= bit_d;
      shift_q      <= shift_d;
      delay_q      <= delay_d;
      poll_q       <= poll_d;
      ack_choice_q <= ack_choice_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
    end
  end

  // Result of this tick.
  always_comb begin
    res_in.scl_out    = scl_d;
    res_in.sda_out    = sda_d;
    res_in.busy_res   = (phase_d != PH_IDLE);
    res_in.done_res   = done;
    res_in.rx_byte    = rx;
    res_in.ack_failed = failed;
  end

  // Result queue control.
  assign empty   = (rcnt_q == 2'd0);
  assign rpop_ok = pop && !empty;
  assign res_o   = rmem_q[rrd_q];
  assign rcnt_d  = rcnt_q + {1'b0, fire} - {1'b0, rpop_ok};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwr_q  <= 1'b0;
      rrd_q  <= 1'b0;
      rcnt_q <= 2'd0;
    end else begin
      if (fire) begin
        rwr_q <= !rwr_q;
      end
      if (rpop_ok) begin
        rrd_q <= !rrd_q;
      end
      rcnt_q <= rcnt_d;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rmem_q[rwr_q] <= res_in;
    end
  end

endmodule

>>> rtl/core/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// I2C master bit engine
// Open-drain SCL/SDA sequencer for start, stop, byte write, acknowledge wait
// and byte read, stepped by one tick request per clock while full is low.
//
//   Channel   Handshake                Payload
//   ticks     push / full              cmd_valid, mode, tx_byte, send_ack, sda_in
//   results   empty / pop              scl_out, sda_out, busy_res, done_res,
//                                      rx_byte, ack_failed
//   config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One tick request is taken per cycle while full is low; each gives one result.
// A result passes through the front queue, then the sequencer step into the
// result queue. Either side may stall: the two-entry queues absorb it, and
// full, from the front queue alone, rises only after the result queue filled.
// Reset empties both queues, idles the sequencer with both lines released
// and loads the register reset values.
// Configuration writes are taken in any cycle; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_macros.svh"

module i2c_master_bit_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Tick requests.
  input  logic        push,
  output logic        full,
  input  logic        cmd_valid_i,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        send_ack_i,
  input  logic        sda_in_i,
  // Results.
  output logic        empty,
  input  logic        pop,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  rx_byte_o,
  output logic        ack_failed_o,
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import i2c_mbe_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    item_pop;
  res_t    res;
  cfg_wr_t cfg_wr;

  // Configuration port.
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // Front part: intake and classification.
  i2c_mbe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .cmd_valid_i  (cmd_valid_i),
    .mode_i       (mode_i),
    .tx_byte_i    (tx_byte_i),
    .send_ack_i   (send_ack_i),
    .sda_in_i     (sda_in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // Back part: bus sequencer and result queue.
  i2c_mbe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .empty        (empty),
    .pop          (pop),
    .res_o        (res)
  );

  // Result ports.
  assign scl_out_o    = res.scl_out;
  assign sda_out_o    = res.sda_out;
  assign busy_res_o   = res.busy_res;
  assign done_res_o   = res.done_res;
  assign rx_byte_o    = res.rx_byte;
  assign ack_failed_o = res.ack_failed;

  // A finished command leaves the sequencer idle.
  `I2C_MBE_ASSERT_NOW(a_done_idle, !empty && done_res_o, !busy_res_o, "done while busy")
  // A failed acknowledge wait is reported only with done.
  `I2C_MBE_ASSERT_NOW(a_fail_done, !empty && ack_failed_o, done_res_o, "fail without done")
  // The failure path ends after the stop sequence with both lines released.
  `I2C_MBE_ASSERT_NOW(a_fail_lines, !empty && ack_failed_o, scl_out_o && sda_out_o,
                      "fail with lines held low")
  // Received data appears only on a done result.
  `I2C_MBE_ASSERT_NOW(a_rx_done, !empty && (rx_byte_o != 8'd0), done_res_o,
                      "rx data without done")

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Steps the engine one bus tick per request and checks every tick result
// against a tick-by-tick software copy of the sequencer. It covers start, stop,
// byte writes and reads, acknowledge waits that pass and that time out, and
// ignored commands. Runs use unit lengths of zero, one, two and eight ticks and
// poll limits from zero to the largest, with random stalls on both queue sides.
// ----------------------------------------------------------------------------
module testbench;
  import i2c_mbe_pkg::*;

  // One bus tick as offered to the engine.
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

  // Sequencer state together with its two registers.
  typedef struct packed {
    phase_e      ph;
    cmd_e        act;
    logic [3:0]  nbits;
    logic [7:0]  shreg;
    logic [23:0] dly;
    logic [7:0]  polls;
    logic        ack_sel;
    logic        scl;
    logic        sda;
    logic [15:0] tpu;
    logic [7:0]  lim;
  } eng_t;

  // SDA held high for the whole command.
  localparam int ALL_HIGH = 1 << 30;
  // An index that selects no register.
  localparam logic [CfgIdxW-1:0] UNUSED_REG_IDX = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic              cmd_valid_i = 1'b0;
  logic [2:0]        mode_i = 3'd0;
  logic [7:0]        tx_byte_i = 8'd0;
  logic              send_ack_i = 1'b0;
  logic              sda_in_i = 1'b1;
  logic              empty;
  logic              pop = 1'b0;
  logic              scl_out_o;
  logic              sda_out_o;
  logic              busy_res_o;
  logic              done_res_o;
  logic [7:0]        rx_byte_o;
  logic              ack_failed_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [15:0]       cfg_data_i = 16'd0;

  tick_t tick_q[$];
  res_t  tick_result_q[$];
  eng_t  plan;
  eng_t  engine;
  tick_t on_port;
  int    ticks_made = 0;
  int    errors = 0;
  int    n_done = 0;
  int    n_fail = 0;
  int    n_cfg = 0;
  int    push_gap = 0;
  int    push_calm = 0;
  int    pop_gap = 0;
  int    pop_calm = 0;

  i2c_master_bit_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_valid_i (cmd_valid_i),
    .mode_i      (mode_i),
    .tx_byte_i   (tx_byte_i),
    .send_ack_i  (send_ack_i),
    .sda_in_i    (sda_in_i),
    .empty       (empty),
    .pop         (pop),
    .scl_out_o   (scl_out_o),
    .sda_out_o   (sda_out_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_byte_o   (rx_byte_o),
    .ack_failed_o(ack_failed_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // State right after reset.
  function automatic eng_t engine_reset();
    eng_t s;
    s = '0;
    s.ph = PH_IDLE;
    s.act = CMD_START;
    s.scl = 1'b1;
    s.sda = 1'b1;
    s.tpu = 16'd8;
    s.lim = 8'd250;
    return s;
  endfunction

  // Enter a phase that holds the lines for a number of units.
  function automatic void hold(inout eng_t s, input phase_e ph, input int unsigned units);
    int unsigned t;
    t = (s.tpu == 16'd0) ? 1 : int'(s.tpu);
    s.ph = ph;
    s.dly = 24'(t * units - 1);
  endfunction

  // Put the next data bit on SDA with SCL low.
  function automatic void shift_out(inout eng_t s);
    s.scl = 1'b0;
    s.sda = s.shreg[7];
    s.shreg = s.shreg << 1;
    hold(s, PH_WSET, 2);
  endfunction

  // Advance the sequencer by one tick and return the line result of that tick.
  function automatic res_t engine_tick(inout eng_t s, input tick_t t);
    res_t r;
    logic done;
    logic [7:0] rx;
    logic failed;
    done = 1'b0;
    rx = 8'd0;
    failed = 1'b0;
    if (s.ph == PH_IDLE) begin
      if (t.cmd_valid && t.mode <= 3'(CMD_READ)) begin
        s.act = cmd_e'(t.mode);
        s.nbits = 4'd0;
        s.polls = 8'd0;
        case (cmd_e'(t.mode))
          CMD_START: begin
            s.scl = 1'b1;
            s.sda = 1'b1;
            hold(s, PH_ST1, 4);
          end
          CMD_STOP: begin
            s.scl = 1'b0;
            s.sda = 1'b0;
            hold(s, PH_SP1, 4);
          end
          CMD_WRITE: begin
            s.shreg = t.tx_byte;
            shift_out(s);
          end
          CMD_WACK: begin
            s.sda = 1'b1;
            hold(s, PH_AREL, 1);
          end
          default: begin
            s.ack_sel = t.send_ack;
            s.shreg = 8'd0;
            s.scl = 1'b0;
            s.sda = 1'b1;
            hold(s, PH_RLO, 2);
          end
        endcase
      end
    end else if (s.dly != 24'd0) begin
      s.dly = s.dly - 24'd1;
    end else begin
      case (s.ph)
        PH_ST1: begin
          s.scl = 1'b1;
          s.sda = 1'b0;
          hold(s, PH_ST2, 4);
        end
        PH_ST2: begin
          s.scl = 1'b0;
          s.sda = 1'b0;
          s.ph = PH_IDLE;
          done = 1'b1;
        end
        PH_SP1: begin
          s.scl = 1'b1;
          s.sda = 1'b0;
          hold(s, PH_SP2, 4);
        end
        PH_SP2: begin
          s.scl = 1'b1;
          s.sda = 1'b1;
          hold(s, PH_SP3, 4);
        end
        PH_SP3: begin
          s.ph = PH_IDLE;
          done = 1'b1;
          failed = (s.act == CMD_WACK);
        end
        PH_WSET: begin
          s.scl = 1'b1;
          hold(s, PH_WHI, 2);
        end
        PH_WHI: begin
          s.scl = 1'b0;
          hold(s, PH_WLO, 2);
        end
        PH_WLO: begin
          s.nbits = s.nbits + 4'd1;
          if (s.nbits >= BITS_PER_BYTE) begin
            s.ph = PH_IDLE;
            done = 1'b1;
          end else begin
            shift_out(s);
          end
        end
        PH_RLO: begin
          s.scl = 1'b1;
          s.sda = 1'b1;
          hold(s, PH_RHI, 1);
        end
        PH_RHI: begin
          s.shreg = {s.shreg[6:0], t.sda_in};
          s.nbits = s.nbits + 4'd1;
          s.scl = 1'b0;
          if (s.nbits >= BITS_PER_BYTE) begin
            s.sda = !s.ack_sel;
            hold(s, PH_RALO, 2);
          end else begin
            s.sda = 1'b1;
            hold(s, PH_RLO, 2);
          end
        end
        PH_RALO: begin
          s.scl = 1'b1;
          hold(s, PH_RAHI, 2);
        end
        PH_RAHI: begin
          s.scl = 1'b0;
          s.ph = PH_IDLE;
          done = 1'b1;
          rx = s.shreg;
        end
        PH_AREL: begin
          s.scl = 1'b1;
          s.sda = 1'b1;
          hold(s, PH_AHI, 1);
        end
        PH_AHI, PH_APOLL: begin
          // The slave acknowledges by pulling SDA low; too many high samples
          // abort the transfer through the stop sequence.
          if (!t.sda_in) begin
            s.scl = 1'b0;
            s.ph = PH_IDLE;
            done = 1'b1;
          end else if (int'(s.polls) + 1 > int'(s.lim)) begin
            s.scl = 1'b0;
            s.sda = 1'b0;
            hold(s, PH_SP1, 4);
          end else begin
            s.polls = s.polls + 8'd1;
            s.ph = PH_APOLL;
            s.dly = 24'd0;
          end
        end
        default: begin
        end
      endcase
    end
    r.scl_out = s.scl;
    r.sda_out = s.sda;
    r.busy_res = (s.ph != PH_IDLE);
    r.done_res = done;
    r.rx_byte = rx;
    r.ack_failed = failed;
    return r;
  endfunction

  function automatic void set_reg(inout eng_t s, input logic [CfgIdxW-1:0] idx,
                                  input logic [15:0] data);
    if (idx == REG_TICKS_PER_UNIT) begin
      s.tpu = data;
    end else if (idx == REG_ACK_POLL_LIMIT) begin
      s.lim = data[7:0];
    end
  endfunction

  // Stall length: mostly none or short, sometimes long, with calm stretches.
  function automatic int pause_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 120);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Queue one tick and follow it in the planning copy of the engine.
  function automatic void queue_tick(input logic v, input logic [2:0] m, input logic [7:0] tx,
                                     input logic ack, input logic sda);
    tick_t t;
    res_t ignored;
    t = '{cmd_valid: v, mode: m, tx_byte: tx, send_ack: ack, sda_in: sda};
    ignored = engine_tick(plan, t);
    tick_q.push_back(t);
    ticks_made++;
  endfunction

  // SDA level for tick n of a command: high for the first hi ticks, random if hi < 0.
  function automatic logic sda_level(input int hi, input int n);
    if (hi < 0) return 1'($urandom_range(0, 1));
    return n < hi;
  endfunction

  // Issue one command while idle and tick it to completion. Ticks while busy
  // carry random commands that the engine must ignore.
  function automatic void run_cmd(input cmd_e m, input logic [7:0] tx, input logic ack,
                                  input int hi);
    int n;
    n = 0;
    queue_tick(1'b1, 3'(m), tx, ack, sda_level(hi, n));
    while (plan.ph != PH_IDLE) begin
      n++;
      queue_tick($urandom_range(0, 3) == 0, 3'($urandom), 8'($urandom), 1'($urandom),
                 sda_level(hi, n));
    end
  endfunction

  // High SDA ticks before the acknowledge: early, late, or never.
  function automatic int ack_delay();
    int span;
    int r;
    span = 2 * ((plan.tpu == 16'd0) ? 1 : int'(plan.tpu)) + 2;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, span);
    if (r < 9) return span + $urandom_range(0, int'(plan.lim) + 2);
    return ALL_HIGH;
  endfunction

  // A complete transfer: start, address, then data bytes in either direction, stop.
  function automatic void bus_transfer();
    int nbytes;
    run_cmd(CMD_START, 8'($urandom), 1'($urandom), -1);
    run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), -1);
    run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), ack_delay());
    nbytes = $urandom_range(1, 3);
    repeat (nbytes) begin
      if ($urandom_range(0, 1)) begin
        run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), -1);
        run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), ack_delay());
      end else begin
        run_cmd(CMD_READ, 8'($urandom), 1'($urandom), -1);
      end
    end
    run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), -1);
  endfunction

  // Out-of-order single commands or undefined modes offered while idle.
  function automatic void loose_cmds();
    cmd_e m;
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(1, 4))
        queue_tick(1'b1, 3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom), 1'($urandom));
    end else begin
      m = cmd_e'($urandom_range(0, 4));
      run_cmd(m, 8'($urandom), 1'($urandom), (m == CMD_WACK) ? ack_delay() : -1);
    end
  endfunction

  // Wait until every queued tick is taken and every result has come back.
  task automatic drain();
    while (tick_q.size() != 0 || push || tick_result_q.size() != 0) @(posedge clk_i);
  endtask

  // Register write, only while the engine is idle and drained.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    set_reg(engine, idx, data);
    set_reg(plan, idx, data);
    n_cfg++;
  endtask

  task automatic random_traffic(input int budget, input bit pause_midway);
    int stop_at;
    bit paused;
    stop_at = ticks_made + budget;
    paused = 1'b0;
    while (ticks_made < stop_at) begin
      if (pause_midway && !paused && ticks_made > stop_at - budget / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) bus_transfer();
      else loose_cmds();
      repeat ($urandom_range(0, 3))
        queue_tick(1'b0, 3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // Tick driver: offers queued ticks and predicts each one as it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      cmd_valid_i <= 1'b0;
      mode_i <= 3'd0;
      tx_byte_i <= 8'd0;
      send_ack_i <= 1'b0;
      sda_in_i <= 1'b1;
    end else begin
      if (push && !full) begin
        tick_result_q.push_back(engine_tick(engine, on_port));
        push_gap = pause_len(push_calm);
      end else if (!push && push_gap > 0) begin
        push_gap--;
      end
      if (!(push && full)) begin
        if (push_gap == 0 && tick_q.size() != 0) begin
          on_port = tick_q.pop_front();
          cmd_valid_i <= on_port.cmd_valid;
          mode_i <= on_port.mode;
          tx_byte_i <= on_port.tx_byte;
          send_ack_i <= on_port.send_ack;
          sda_in_i <= on_port.sda_in;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each popped result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (tick_result_q.size() == 0) begin
          $error("result popped with no tick outstanding");
          errors++;
        end else begin
          want = tick_result_q.pop_front();
          check_field("scl_out", 8'(want.scl_out), 8'(scl_out_o));
          check_field("sda_out", 8'(want.sda_out), 8'(sda_out_o));
          check_field("busy_res", 8'(want.busy_res), 8'(busy_res_o));
          check_field("done_res", 8'(want.done_res), 8'(done_res_o));
          check_field("rx_byte", want.rx_byte, rx_byte_o);
          check_field("ack_failed", 8'(want.ack_failed), 8'(ack_failed_o));
          n_done += want.done_res;
          n_fail += want.ack_failed;
        end
        pop_gap = pause_len(pop_calm);
      end else if (!pop && pop_gap > 0) begin
        pop_gap--;
      end
      pop <= (pop_gap == 0);
    end
  end

  // Stimulus: directed commands, then random transfers under several settings.
  initial begin
    plan = engine_reset();
    engine = engine_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset unit length and poll limit.
    run_cmd(CMD_START, 8'h00, 1'b0, -1);
    run_cmd(CMD_WACK, 8'h00, 1'b0, 0);
    run_cmd(CMD_STOP, 8'h00, 1'b0, -1);

    // Fastest timing: every command, data extremes, ack found and timed out.
    write_reg(REG_TICKS_PER_UNIT, 16'd1);
    write_reg(REG_ACK_POLL_LIMIT, 16'd3);
    queue_tick(1'b1, 3'd5, 8'hFF, 1'b1, 1'b0);
    queue_tick(1'b1, 3'd6, 8'h00, 1'b0, 1'b1);
    queue_tick(1'b1, 3'd7, 8'hFF, 1'b1, 1'b1);
    run_cmd(CMD_START, 8'h00, 1'b0, -1);
    run_cmd(CMD_WRITE, 8'h00, 1'b1, -1);
    run_cmd(CMD_WRITE, 8'hFF, 1'b0, -1);
    run_cmd(CMD_WACK, 8'h00, 1'b0, 0);
    run_cmd(CMD_WACK, 8'h00, 1'b0, 4);
    run_cmd(CMD_WACK, 8'h00, 1'b0, ALL_HIGH);
    run_cmd(CMD_READ, 8'h00, 1'b1, ALL_HIGH);
    run_cmd(CMD_READ, 8'hFF, 1'b0, 0);
    run_cmd(CMD_STOP, 8'h00, 1'b0, -1);
    random_traffic(100, 1'b1);

    // A zero unit length counts as one tick; a zero limit fails on the first high sample.
    write_reg(REG_TICKS_PER_UNIT, 16'h0000);
    write_reg(REG_ACK_POLL_LIMIT, 16'hFF00);
    run_cmd(CMD_WACK, 8'h00, 1'b0, ALL_HIGH);
    run_cmd(CMD_WACK, 8'h00, 1'b0, 0);
    random_traffic(100, 1'b0);

    // Largest poll limit, run out once.
    write_reg(REG_TICKS_PER_UNIT, 16'd2);
    write_reg(REG_ACK_POLL_LIMIT, 16'd255);
    run_cmd(CMD_WACK, 8'h00, 1'b0, ALL_HIGH);

    // The unused index changes nothing.
    write_reg(UNUSED_REG_IDX, 16'h5A5A);
    run_cmd(CMD_START, 8'h00, 1'b0, -1);
    run_cmd(CMD_STOP, 8'h00, 1'b0, -1);

    write_reg(REG_TICKS_PER_UNIT, 16'd1);
    write_reg(REG_ACK_POLL_LIMIT, 16'd1);
    random_traffic(100, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d bus ticks with %0d finished commands, %0d of them failed acks,",
             ticks_made, n_done, n_fail);
    $display("across %0d register writes with unit lengths of zero, one, two and eight.",
             n_cfg);
    if (errors == 0) begin
      $display("i2c_master_bit_engine: match");
    end else begin
      $display("i2c_master_bit_engine: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #200_000_000;
    $display("i2c_master_bit_engine: mismatch");
    $finish;
  end

endmodule
